// ----- design/dld_pkg.sv -----
// Shared types and constants for the Damerau-Levenshtein distance engine.
package dld_pkg;

  localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
  localparam logic [1:0] OP_COMPUTE       = 2'd2;
  localparam logic [1:0] OP_RESERVED      = 2'd3;

  localparam logic [1:0] CFG_INSERT    = 2'd0;
  localparam logic [1:0] CFG_DELETE    = 2'd1;
  localparam logic [1:0] CFG_SUBSTITUTE = 2'd2;
  localparam logic [1:0] CFG_TRANSPOSE = 2'd3;

  localparam int COST_BITS = 4;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] symbol;
  } dld_in_t;

  typedef struct packed {
    logic [15:0] distance;
    logic        too_long;
  } dld_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ROW_RD,
    ST_ROW_LATCH,
    ST_CELL_RD_Y,
    ST_CELL_RD_LR,
    ST_CELL_ADDR,
    ST_CELL_RD_T,
    ST_CELL_CALC,
    ST_CELL_WR,
    ST_ROW_END,
    ST_DONE
  } dld_state_t;

  typedef struct packed {
    logic take_item;
    logic clear_step;
    logic first_row;
    logic row_rd;
    logic row_latch;
    logic rd_y;
    logic rd_lr;
    logic calc_addr;
    logic rd_t;
    logic calc;
    logic write_cell;
    logic row_end;
    logic finish;
  } dld_cmd_t;

  typedef struct packed {
    logic is_compute;
    logic overflow;
    logic empty;
    logic clr_last;
    logic j_last;
    logic i_last;
    logic out_busy;
  } dld_sts_t;

endpackage

// ----- design/dld_ctrl.sv -----
// Sequencer for loading, clearing and walking the distance table.
module dld_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  dld_pkg::dld_sts_t sts,
  output dld_pkg::dld_cmd_t cmd,
  output logic              idle
);

  dld_pkg::dld_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dld_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dld_pkg::ST_IDLE: begin
        if (in_valid && sts.is_compute) begin
          state_nxt = (sts.overflow || sts.empty) ? dld_pkg::ST_DONE : dld_pkg::ST_CLEAR;
        end
      end
      dld_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = dld_pkg::ST_ROW_RD;
      end
      dld_pkg::ST_ROW_RD:     state_nxt = dld_pkg::ST_ROW_LATCH;
      dld_pkg::ST_ROW_LATCH:  state_nxt = dld_pkg::ST_CELL_RD_Y;
      dld_pkg::ST_CELL_RD_Y:  state_nxt = dld_pkg::ST_CELL_RD_LR;
      dld_pkg::ST_CELL_RD_LR: state_nxt = dld_pkg::ST_CELL_ADDR;
      dld_pkg::ST_CELL_ADDR:  state_nxt = dld_pkg::ST_CELL_RD_T;
      dld_pkg::ST_CELL_RD_T:  state_nxt = dld_pkg::ST_CELL_CALC;
      dld_pkg::ST_CELL_CALC:  state_nxt = dld_pkg::ST_CELL_WR;
      dld_pkg::ST_CELL_WR: begin
        state_nxt = sts.j_last ? dld_pkg::ST_ROW_END : dld_pkg::ST_CELL_RD_Y;
      end
      dld_pkg::ST_ROW_END: begin
        state_nxt = sts.i_last ? dld_pkg::ST_DONE : dld_pkg::ST_ROW_RD;
      end
      dld_pkg::ST_DONE: begin
        if (!sts.out_busy) state_nxt = dld_pkg::ST_IDLE;
      end
      default: state_nxt = dld_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    unique case (state_r)
      dld_pkg::ST_IDLE: begin
        idle          = 1'b1;
        cmd.take_item = in_valid;
      end
      dld_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        cmd.first_row  = sts.clr_last;
      end
      dld_pkg::ST_ROW_RD:     cmd.row_rd     = 1'b1;
      dld_pkg::ST_ROW_LATCH:  cmd.row_latch  = 1'b1;
      dld_pkg::ST_CELL_RD_Y:  cmd.rd_y       = 1'b1;
      dld_pkg::ST_CELL_RD_LR: cmd.rd_lr      = 1'b1;
      dld_pkg::ST_CELL_ADDR:  cmd.calc_addr  = 1'b1;
      dld_pkg::ST_CELL_RD_T:  cmd.rd_t       = 1'b1;
      dld_pkg::ST_CELL_CALC:  cmd.calc       = 1'b1;
      dld_pkg::ST_CELL_WR:    cmd.write_cell = 1'b1;
      dld_pkg::ST_ROW_END:    cmd.row_end    = 1'b1;
      dld_pkg::ST_DONE:       cmd.finish     = !sts.out_busy;
      default: ;
    endcase
  end

  // A compute item never leaves the sequencer idle on the next cycle.
  a_compute_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dld_pkg::ST_IDLE && in_valid && sts.is_compute)
      |=> state_r != dld_pkg::ST_IDLE)
    else $error("compute item did not start the sequencer");

  a_done_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dld_pkg::ST_DONE && !sts.out_busy) |=> state_r == dld_pkg::ST_IDLE)
    else $error("finished compute did not return to idle");

  a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !cmd.finish)
    else $error("result issued twice");

endmodule

// ----- design/dld_dpath.sv -----
// Strings, tables, counters and cell arithmetic of the distance engine.
module dld_dpath #(
  parameter int MAX_LEN     = 64,
  parameter int SYMBOL_BITS = 8,
  parameter int DIST_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dld_pkg::dld_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output dld_pkg::dld_out_t            out_data,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [dld_pkg::COST_BITS-1:0] cfg_wdata,
  input  dld_pkg::dld_cmd_t            cmd,
  output dld_pkg::dld_sts_t            sts
);

  localparam int STRIDE  = MAX_LEN + 2;
  localparam int DEPTH   = STRIDE * STRIDE;
  localparam int AW      = $clog2(DEPTH);
  localparam int LW      = $clog2(MAX_LEN + 1);
  localparam int SW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SUMW    = DIST_BITS + LW + 2;
  localparam int SYMS    = 1 << SYMBOL_BITS;
  localparam logic [DIST_BITS-1:0] DMAX = {DIST_BITS{1'b1}};
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);

  function automatic logic [DIST_BITS-1:0] sat_f(input logic [SUMW-1:0] v);
    return (v > SUMW'(DMAX)) ? DMAX : v[DIST_BITS-1:0];
  endfunction

  logic [dld_pkg::COST_BITS-1:0] ins_r, del_r, sub_r, tra_r;
  logic [LW-1:0]          xl_r, yl_r;
  logic                   ovf_r;
  logic [SYMBOL_BITS-1:0] first_mem [MAX_LEN];
  logic [SYMBOL_BITS-1:0] second_mem [MAX_LEN];
  logic [LW-1:0]          lr_mem [SYMS];
  logic [DIST_BITS-1:0]   tab_mem [DEPTH];
  logic [SYMBOL_BITS-1:0] x_rd, y_rd, xs_r;
  logic [LW-1:0]          lr_rd;
  logic [DIST_BITS-1:0]   up_rd, t_rd;
  logic [LW-1:0]          i_r, j_r, mc_r;
  logic [AW-1:0]          taddr_r, rb_r, rbn_r;
  logic [DIST_BITS-1:0]   up_val_r, diag_r, left_r, best_r, last_r;
  logic [SYMBOL_BITS-1:0] clr_cnt_r;
  logic                   out_valid_r;
  dld_pkg::dld_out_t      out_data_r;

  logic [SYMBOL_BITS-1:0] sym_m;
  logic                   empty;
  logic [DIST_BITS-1:0]   sent, up_val, diag_val, left_val, tv, best;
  logic [SUMW-1:0]        c0, c1, c2, c3, m01, m23;
  logic [DIST_BITS-1:0]   res;
  logic [31:0]            res32;

  assign sym_m = SYMBOL_BITS'(in_data.symbol);
  assign empty = (xl_r == '0) || (yl_r == '0);
  assign sent  = sat_f(SUMW'(xl_r) + SUMW'(yl_r));

  // Border cells are not stored: row 0 and column 0 hold the sentinel,
  // row 1 and column 1 hold the offset from the corner.
  assign up_val   = (i_r == LW'(1)) ? sat_f(SUMW'(j_r)) : up_rd;
  assign diag_val = (j_r == LW'(1)) ? sat_f(SUMW'(i_r) - SUMW'(1)) : diag_r;
  assign left_val = (j_r == LW'(1)) ? sat_f(SUMW'(i_r)) : left_r;

  always_comb begin
    priority if (lr_rd == '0 || mc_r == '0) begin
      tv = sent;
    end else if (lr_rd == LW'(1)) begin
      tv = sat_f(SUMW'(mc_r) - SUMW'(1));
    end else if (mc_r == LW'(1)) begin
      tv = sat_f(SUMW'(lr_rd) - SUMW'(1));
    end else begin
      tv = t_rd;
    end
  end

  assign c0 = SUMW'(diag_val) + ((xs_r != y_rd) ? SUMW'(sub_r) : '0);
  assign c1 = SUMW'(left_val) + SUMW'(ins_r);
  assign c2 = SUMW'(up_val) + SUMW'(del_r);
  assign c3 = SUMW'(tv) + (SUMW'(i_r) - SUMW'(lr_rd) - SUMW'(1)) + SUMW'(tra_r)
            + (SUMW'(j_r) - SUMW'(mc_r) - SUMW'(1));
  assign m01  = (c0 < c1) ? c0 : c1;
  assign m23  = (c2 < c3) ? c2 : c3;
  assign best = sat_f((m01 < m23) ? m01 : m23);

  assign res   = ovf_r ? '0 : (empty ? sent : last_r);
  assign res32 = 32'(res);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_r       <= dld_pkg::COST_BITS'(1);
      del_r       <= dld_pkg::COST_BITS'(1);
      sub_r       <= dld_pkg::COST_BITS'(1);
      tra_r       <= dld_pkg::COST_BITS'(1);
      xl_r        <= '0;
      yl_r        <= '0;
      ovf_r       <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          dld_pkg::CFG_INSERT:     ins_r <= cfg_wdata;
          dld_pkg::CFG_DELETE:     del_r <= cfg_wdata;
          dld_pkg::CFG_SUBSTITUTE: sub_r <= cfg_wdata;
          dld_pkg::CFG_TRANSPOSE:  tra_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.take_item && in_data.op == dld_pkg::OP_APPEND_FIRST) begin
        if (xl_r < LEN_MAX) xl_r <= xl_r + LW'(1);
        else                ovf_r <= 1'b1;
      end
      if (cmd.take_item && in_data.op == dld_pkg::OP_APPEND_SECOND) begin
        if (yl_r < LEN_MAX) yl_r <= yl_r + LW'(1);
        else                ovf_r <= 1'b1;
      end
      if (cmd.clear_step) clr_cnt_r <= clr_cnt_r + SYMBOL_BITS'(1);
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        xl_r        <= '0;
        yl_r        <= '0;
        ovf_r       <= 1'b0;
      end
    end
  end

  // string memories
  always_ff @(posedge clk) begin
    if (cmd.take_item && in_data.op == dld_pkg::OP_APPEND_FIRST && xl_r < LEN_MAX)
      first_mem[xl_r[SW-1:0]] <= sym_m;
    if (cmd.take_item && in_data.op == dld_pkg::OP_APPEND_SECOND && yl_r < LEN_MAX)
      second_mem[yl_r[SW-1:0]] <= sym_m;
    if (cmd.row_rd) x_rd <= first_mem[SW'(i_r - LW'(1))];
    if (cmd.rd_y)   y_rd <= second_mem[SW'(j_r - LW'(1))];
  end

  // last row seen per symbol
  always_ff @(posedge clk) begin
    if (cmd.clear_step)   lr_mem[clr_cnt_r] <= '0;
    else if (cmd.row_end) lr_mem[xs_r] <= i_r;
    if (cmd.rd_lr) lr_rd <= lr_mem[y_rd];
  end

  // cost table, interior cells only
  always_ff @(posedge clk) begin
    if (cmd.write_cell) tab_mem[rbn_r + AW'(j_r) + AW'(1)] <= best_r;
    if (cmd.rd_lr)      up_rd <= tab_mem[rb_r + AW'(j_r) + AW'(1)];
    if (cmd.rd_t)       t_rd  <= tab_mem[taddr_r];
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.first_row) begin
      i_r   <= LW'(1);
      rb_r  <= AW'(STRIDE);
      rbn_r <= AW'(2 * STRIDE);
    end
    if (cmd.row_latch) begin
      xs_r <= x_rd;
      j_r  <= LW'(1);
      mc_r <= '0;
    end
    if (cmd.calc_addr) taddr_r <= AW'(lr_rd) * AW'(STRIDE) + AW'(mc_r);
    if (cmd.calc) begin
      best_r   <= best;
      up_val_r <= up_val;
    end
    if (cmd.write_cell) begin
      left_r <= best_r;
      diag_r <= up_val_r;
      last_r <= best_r;
      if (xs_r == y_rd) mc_r <= j_r;
      j_r <= j_r + LW'(1);
    end
    if (cmd.row_end) begin
      i_r   <= i_r + LW'(1);
      rb_r  <= rb_r + AW'(STRIDE);
      rbn_r <= rbn_r + AW'(STRIDE);
    end
    if (cmd.finish) begin
      out_data_r.distance <= res32[15:0];
      out_data_r.too_long <= ovf_r;
    end
  end

  assign sts.is_compute = (in_data.op == dld_pkg::OP_COMPUTE);
  assign sts.overflow   = ovf_r;
  assign sts.empty      = empty;
  assign sts.clr_last   = &clr_cnt_r;
  assign sts.j_last     = (j_r == yl_r);
  assign sts.i_last     = (i_r == xl_r);
  assign sts.out_busy   = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cell_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_cell |-> (j_r >= LW'(1) && j_r <= yl_r && i_r >= LW'(1) && i_r <= xl_r))
    else $error("cell write outside the loaded strings");

  a_match_before_col: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc |-> (mc_r < j_r && lr_rd < i_r))
    else $error("transposition source not behind current cell");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(out_valid_r) && $past(rst_n)) |-> $past(!out_stall))
    else $error("result dropped while stalled");

endmodule

// ----- design/damerau_levenshtein_distance.sv -----
// Top level of the unrestricted Damerau-Levenshtein distance engine.
//
// Usage: items arrive on in_data with in_valid; an item is taken on a
// clock edge where in_valid is high and in_stall is low. Op append-first
// and append-second add one symbol to a string (up to MAX_LEN each;
// extra symbols are dropped and flag the pair as too long). Op compute
// yields one result item on out_data, then both strings are emptied.
// Op 3 is taken and ignored.
// A compute item clears all 2^SYMBOL_BITS entries of the last-row-seen
// table, one entry a cycle, then walks the table: each cell reads in
// turn the second-string symbol, the last-row table, then the
// transposition cell, and each row first reads a first-string symbol.
// Empty or too-long pairs skip the clear and the walk. Costs are
// written on cfg_we/cfg_index/cfg_wdata; the user must do so only while
// idle, as the block does not enforce it. Reset (rst_n low,
// synchronous) sets all costs to 1, empties both strings and drops any
// pending result. A stalled result stays on out_data; appends are still
// taken meanwhile, a compute waits for it.
module damerau_levenshtein_distance #(
  parameter int MAX_LEN     = 64,
  parameter int SYMBOL_BITS = 8,
  parameter int DIST_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dld_pkg::dld_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dld_pkg::dld_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [dld_pkg::COST_BITS-1:0] cfg_wdata
);

  dld_pkg::dld_cmd_t cmd;
  dld_pkg::dld_sts_t sts;
  logic              idle;

  // sequencer: owns intake, table clear, walk order and result handoff
  dld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle)
  );

  // datapath: strings, tables, cost arithmetic and result register
  dld_dpath #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS),
    .DIST_BITS   (DIST_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  // items are taken only while the sequencer rests
  assign in_stall = !idle;

endmodule
